// ----- design/tnac_pkg.sv -----
// ----------------------------------------------------------------------------
// tnac_pkg
// widths, constants and sideband types for the triangle normal, area and
// centroid pipeline
// ----------------------------------------------------------------------------
package tnac_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int NORMAL_FRAC = 14;
    localparam int AREA_WIDTH  = 37;
    localparam int THR_WIDTH   = 12;

    localparam int EDGE_W     = COORD_WIDTH + 1;
    localparam int PROD_W     = 2 * EDGE_W;
    localparam int MAG_W      = 2 * COORD_WIDTH + 1;
    localparam int SPLIT_W    = (MAG_W + 1) / 2;
    localparam int HI_W       = MAG_W - SPLIT_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int AREA_SHIFT = 13;
    localparam int RAD_W      = SUM_W - 2 * AREA_SHIFT;
    localparam int NORM_BITS  = 30;
    localparam int BLEN_W     = $clog2(MAG_W + 1);
    localparam int NSQ_W      = 2 * NORM_BITS + 2;

    localparam int U_W     = COORD_WIDTH + 2;
    localparam int CENT_SH = U_W + 1;
    localparam logic [U_W-1:0] CENT_K   = U_W'(((64'd1 << CENT_SH) + 64'd2) / 64'd3);
    localparam logic [U_W-1:0] CENT_OFS = U_W'(64'd3 * (64'd1 << (COORD_WIDTH - 1)) + 64'd1);

    localparam int ISQ_STEPS = 2;
    localparam int DIV_STEPS = 2;

    typedef struct packed {
        logic [2:0]                      neg;
        logic [2:0][COORD_WIDTH-1:0]     center;
    } t_meta;

    typedef struct packed {
        logic [AREA_WIDTH-1:0] area;
        logic                  degen;
        t_meta                 meta;
    } t_dside;

endpackage

// ----- design/tnac_if.sv -----
// ----------------------------------------------------------------------------
// tnac interfaces
// valid/ready channels for triangle beats, result beats and the threshold
// ----------------------------------------------------------------------------
interface tnac_in_if;
    import tnac_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p0_z;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p1_z;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic signed [COORD_WIDTH-1:0] p2_z;
    modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    input ready);
    modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    output ready);
endinterface

interface tnac_out_if #(
    parameter int NORMAL_FRAC = tnac_pkg::NORMAL_FRAC
);
    import tnac_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [AREA_WIDTH-1:0]         area;
    logic signed [NORMAL_FRAC+1:0] normal_x;
    logic signed [NORMAL_FRAC+1:0] normal_y;
    logic signed [NORMAL_FRAC+1:0] normal_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic                          degenerate;
    modport source (output valid, area, normal_x, normal_y, normal_z,
                    center_x, center_y, center_z, degenerate, input ready);
    modport sink   (input valid, area, normal_x, normal_y, normal_z,
                    center_x, center_y, center_z, degenerate, output ready);
endinterface

interface tnac_cfg_if;
    import tnac_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [THR_WIDTH-1:0] area_threshold;
    modport source (output valid, area_threshold, input ready);
    modport sink   (input valid, area_threshold, output ready);
endinterface

// ----- design/tnac_isqrt.sv -----
// ----------------------------------------------------------------------------
// tnac_isqrt
// pipelined digit-by-digit integer square root with sideband
// ----------------------------------------------------------------------------
module tnac_isqrt #(
    parameter int IN_W   = 74,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [IN_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [IN_W/2-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);
    localparam int ROOT_W = IN_W / 2;
    localparam int NSTG   = (ROOT_W + STEPS - 1) / STEPS;

    logic [IN_W:0]       a_rem  [NSTG+1];
    logic [ROOT_W-1:0]   a_root [NSTG+1];
    logic [SIDE_W-1:0]   a_side [NSTG+1];
    logic [NSTG:0]       a_v;

    logic [IN_W:0]       r_rem  [NSTG];
    logic [ROOT_W-1:0]   r_root [NSTG];
    logic [SIDE_W-1:0]   r_side [NSTG];
    logic [NSTG-1:0]     r_v;
    logic [IN_W:0]       n_rem  [NSTG];
    logic [ROOT_W-1:0]   n_root [NSTG];

    assign a_rem[0]  = (IN_W+1)'(i_rad);
    assign a_root[0] = '0;
    assign a_side[0] = i_side;
    assign a_v[0]    = i_valid;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        always_comb begin : c_step
            logic [IN_W:0]     rem;
            logic [IN_W:0]     d;
            logic [ROOT_W-1:0] root;
            int                bi;
            rem  = a_rem[s];
            root = a_root[s];
            d    = '0;
            for (int k = 0; k < STEPS; k++) begin
                bi = ROOT_W - 1 - (s * STEPS + k);
                if (bi >= 0) begin
                    d = ((IN_W+1)'(root) << (bi + 1)) | ((IN_W+1)'(1) << (2 * bi));
                    if (d <= rem) begin
                        rem  = rem - d;
                        root = root | (ROOT_W'(1) << bi);
                    end
                end
            end
            n_rem[s]  = rem;
            n_root[s] = root;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
                r_side[s] <= a_side[s];
            end
        end

        assign a_rem[s+1]  = r_rem[s];
        assign a_root[s+1] = r_root[s];
        assign a_side[s+1] = r_side[s];
        assign a_v[s+1]    = r_v[s];
    end

    assign o_valid = a_v[NSTG];
    assign o_root  = a_root[NSTG];
    assign o_side  = a_side[NSTG];

endmodule

// ----- design/tnac_div.sv -----
// ----------------------------------------------------------------------------
// tnac_div
// pipelined restoring divider, several numerators over one shared divisor
// ----------------------------------------------------------------------------
module tnac_div #(
    parameter int LANES  = 3,
    parameter int NUM_W  = 45,
    parameter int DEN_W  = 31,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int XW   = DEN_W + Q_W;
    localparam int NSTG = (Q_W + STEPS - 1) / STEPS;

    logic [LANES-1:0][XW-1:0]  a_rem  [NSTG+1];
    logic [LANES-1:0][Q_W-1:0] a_q    [NSTG+1];
    logic [DEN_W-1:0]          a_den  [NSTG+1];
    logic [SIDE_W-1:0]         a_side [NSTG+1];
    logic [NSTG:0]             a_v;

    logic [LANES-1:0][XW-1:0]  r_rem  [NSTG];
    logic [LANES-1:0][Q_W-1:0] r_q    [NSTG];
    logic [DEN_W-1:0]          r_den  [NSTG];
    logic [SIDE_W-1:0]         r_side [NSTG];
    logic [NSTG-1:0]           r_v;
    logic [LANES-1:0][XW-1:0]  n_rem  [NSTG];
    logic [LANES-1:0][Q_W-1:0] n_q    [NSTG];

    for (genvar l = 0; l < LANES; l++) begin : g_in
        assign a_rem[0][l] = XW'(i_num[l]);
    end
    assign a_q[0]    = '0;
    assign a_den[0]  = i_den;
    assign a_side[0] = i_side;
    assign a_v[0]    = i_valid;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        always_comb begin : c_step
            logic [LANES-1:0][XW-1:0]  rem;
            logic [LANES-1:0][Q_W-1:0] q;
            logic [XW-1:0]             d;
            int                        qi;
            rem = a_rem[s];
            q   = a_q[s];
            d   = '0;
            for (int k = 0; k < STEPS; k++) begin
                qi = Q_W - 1 - (s * STEPS + k);
                if (qi >= 0) begin
                    d = XW'(a_den[s]) << qi;
                    for (int l = 0; l < LANES; l++) begin
                        if (d <= rem[l]) begin
                            rem[l] = rem[l] - d;
                            q[l]   = q[l] | (Q_W'(1) << qi);
                        end
                    end
                end
            end
            n_rem[s] = rem;
            n_q[s]   = q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= a_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_den[s]  <= a_den[s];
                r_side[s] <= a_side[s];
            end
        end

        assign a_rem[s+1]  = r_rem[s];
        assign a_q[s+1]    = r_q[s];
        assign a_den[s+1]  = r_den[s];
        assign a_side[s+1] = r_side[s];
        assign a_v[s+1]    = r_v[s];
    end

    assign o_valid = a_v[NSTG];
    assign o_quo   = a_q[NSTG];
    assign o_side  = a_side[NSTG];

endmodule

// ----- design/triangle_normal_area_centroid.sv -----
// ----------------------------------------------------------------------------
// triangle_normal_area_centroid: face normal, area and centroid of a triangle
// an input beat passes 8 front stages, 19 square root stages at two result bits
// each, 1 setup stage, 8 divider stages and the output stage to the result beat
// throughput one triangle per cycle; a held result beat stalls the whole pipe
// synchronous active-low reset clears valid bits and the threshold register
// ----------------------------------------------------------------------------
module triangle_normal_area_centroid #(
    parameter int NORMAL_FRAC = tnac_pkg::NORMAL_FRAC
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tnac_in_if.sink     i_tri,
    tnac_cfg_if.sink    i_cfg,
    tnac_out_if.source  o_res
);
    import tnac_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int NB    = NORM_BITS;
    localparam int DEN_W = NB + 1;
    localparam int Q_W   = NORMAL_FRAC + 1;
    localparam int N_W   = NORMAL_FRAC + 2;
    localparam int NUM_W = NB + NORMAL_FRAC + 1;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << NORMAL_FRAC;

    logic w_en;

    // threshold register
    logic [THR_WIDTH-1:0] r_thr;
    assign i_cfg.ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.area_threshold;
        end
    end

    // valid bits of the front, setup and output stages
    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v, r_h_v, r_j_v, r_out_v;

    // stage a: edges and offset vertex sums
    logic signed [CW-1:0]     w_p0 [3];
    logic signed [CW-1:0]     w_p1 [3];
    logic signed [CW-1:0]     w_p2 [3];
    logic signed [EDGE_W-1:0] r_a_e1 [3];
    logic signed [EDGE_W-1:0] r_a_e2 [3];
    logic [U_W-1:0]           r_a_u  [3];

    assign w_p0[0] = i_tri.p0_x;
    assign w_p0[1] = i_tri.p0_y;
    assign w_p0[2] = i_tri.p0_z;
    assign w_p1[0] = i_tri.p1_x;
    assign w_p1[1] = i_tri.p1_y;
    assign w_p1[2] = i_tri.p1_z;
    assign w_p2[0] = i_tri.p2_x;
    assign w_p2[1] = i_tri.p2_y;
    assign w_p2[2] = i_tri.p2_z;

    assign i_tri.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a_e1[k] <= $signed({w_p1[k][CW-1], w_p1[k]})
                           - $signed({w_p0[k][CW-1], w_p0[k]});
                r_a_e2[k] <= $signed({w_p2[k][CW-1], w_p2[k]})
                           - $signed({w_p0[k][CW-1], w_p0[k]});
                r_a_u[k]  <= {{2{w_p0[k][CW-1]}}, w_p0[k]}
                           + {{2{w_p1[k][CW-1]}}, w_p1[k]}
                           + {{2{w_p2[k][CW-1]}}, w_p2[k]} + CENT_OFS;
            end
        end
    end

    // stage b: cross products and divide-by-three multiply
    logic signed [PROD_W-1:0] r_b_pr [6];
    logic [2*U_W-1:0]         r_b_q  [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_pr[0] <= r_a_e1[1] * r_a_e2[2];
            r_b_pr[1] <= r_a_e1[2] * r_a_e2[1];
            r_b_pr[2] <= r_a_e1[2] * r_a_e2[0];
            r_b_pr[3] <= r_a_e1[0] * r_a_e2[2];
            r_b_pr[4] <= r_a_e1[0] * r_a_e2[1];
            r_b_pr[5] <= r_a_e1[1] * r_a_e2[0];
            for (int k = 0; k < 3; k++) begin
                r_b_q[k] <= (2*U_W)'(r_a_u[k]) * (2*U_W)'(CENT_K);
            end
        end
    end

    // stage c: cross terms and centroid
    logic signed [PROD_W-1:0] r_c_cr [3];
    t_meta                    r_c_meta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_meta.neg <= '0;
            for (int k = 0; k < 3; k++) begin
                r_c_cr[k]          <= r_b_pr[2*k] - r_b_pr[2*k+1];
                r_c_meta.center[k] <= {~r_b_q[k][CENT_SH+CW-1], r_b_q[k][CENT_SH +: CW-1]};
            end
        end
    end

    // stage d: magnitudes and signs
    logic [MAG_W-1:0] r_d_mag [3];
    t_meta            r_d_meta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_meta.center <= r_c_meta.center;
            for (int k = 0; k < 3; k++) begin
                r_d_mag[k]      <= MAG_W'(r_c_cr[k][PROD_W-1] ? -r_c_cr[k] : r_c_cr[k]);
                r_d_meta.neg[k] <= r_c_cr[k][PROD_W-1];
            end
        end
    end

    // stage e: square partial products and leading-one position
    logic [2*HI_W-1:0]         r_e_hh [3];
    logic [HI_W+SPLIT_W-1:0]   r_e_hl [3];
    logic [2*SPLIT_W-1:0]      r_e_ll [3];
    logic [MAG_W-1:0]          r_e_mag [3];
    logic [BLEN_W-1:0]         r_e_b;
    t_meta                     r_e_meta;
    logic [MAG_W-1:0]          w_any;
    logic [BLEN_W-1:0]         w_blen;

    assign w_any = r_d_mag[0] | r_d_mag[1] | r_d_mag[2];
    always_comb begin
        w_blen = '0;
        for (int k = 0; k < MAG_W; k++) begin
            if (w_any[k]) begin
                w_blen = BLEN_W'(k + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_b    <= w_blen;
            r_e_meta <= r_d_meta;
            for (int k = 0; k < 3; k++) begin
                r_e_mag[k] <= r_d_mag[k];
                r_e_hh[k]  <= (2*HI_W)'(r_d_mag[k][MAG_W-1:SPLIT_W])
                            * (2*HI_W)'(r_d_mag[k][MAG_W-1:SPLIT_W]);
                r_e_hl[k]  <= (HI_W+SPLIT_W)'(r_d_mag[k][MAG_W-1:SPLIT_W])
                            * (HI_W+SPLIT_W)'(r_d_mag[k][SPLIT_W-1:0]);
                r_e_ll[k]  <= (2*SPLIT_W)'(r_d_mag[k][SPLIT_W-1:0])
                            * (2*SPLIT_W)'(r_d_mag[k][SPLIT_W-1:0]);
            end
        end
    end

    // stage f: full squares and normalized components
    logic [SQ_W-1:0] r_f_sq [3];
    logic [NB-1:0]   r_f_c  [3];
    t_meta           r_f_meta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_meta <= r_e_meta;
            for (int k = 0; k < 3; k++) begin
                r_f_sq[k] <= (SQ_W'(r_e_hh[k]) << (2*SPLIT_W))
                           + (SQ_W'(r_e_hl[k]) << (SPLIT_W+1)) + SQ_W'(r_e_ll[k]);
                if (r_e_b > BLEN_W'(NB)) begin
                    r_f_c[k] <= NB'(r_e_mag[k] >> (r_e_b - BLEN_W'(NB)));
                end else begin
                    r_f_c[k] <= NB'(r_e_mag[k] << (BLEN_W'(NB) - r_e_b));
                end
            end
        end
    end

    // stage g: sum of squares and normalized squares
    logic [SUM_W-1:0] r_g_s;
    logic [2*NB-1:0]  r_g_c2 [3];
    logic [NB-1:0]    r_g_c  [3];
    t_meta            r_g_meta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_meta <= r_f_meta;
            r_g_s    <= SUM_W'(r_f_sq[0]) + SUM_W'(r_f_sq[1]) + SUM_W'(r_f_sq[2]);
            for (int k = 0; k < 3; k++) begin
                r_g_c[k]  <= r_f_c[k];
                r_g_c2[k] <= (2*NB)'(r_f_c[k]) * (2*NB)'(r_f_c[k]);
            end
        end
    end

    // stage h: radicands
    logic [RAD_W-1:0]       r_h_rad;
    logic [NSQ_W-1:0]       r_h_ns;
    logic [2:0][NB-1:0]     r_h_c;
    t_meta                  r_h_meta;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_meta <= r_g_meta;
            r_h_rad  <= r_g_s[SUM_W-1 -: RAD_W];
            r_h_ns   <= NSQ_W'(r_g_c2[0]) + NSQ_W'(r_g_c2[1]) + NSQ_W'(r_g_c2[2]);
            for (int k = 0; k < 3; k++) begin
                r_h_c[k] <= r_g_c[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_tri.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
    end

    // square roots: area and normal length
    logic                 w_sa_v;
    logic [AREA_WIDTH-1:0] w_area;
    t_meta                w_sa_meta;
    logic                 w_sn_v;
    logic [RAD_W/2-1:0]   w_root;
    logic [2:0][NB-1:0]   w_sn_c;

    tnac_isqrt #(
        .IN_W   (RAD_W),
        .SIDE_W ($bits(t_meta)),
        .STEPS  (ISQ_STEPS)
    ) u_isqrt_area (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_v),
        .i_rad   (r_h_rad),
        .i_side  (r_h_meta),
        .o_valid (w_sa_v),
        .o_root  (w_area),
        .o_side  (w_sa_meta)
    );

    tnac_isqrt #(
        .IN_W   (RAD_W),
        .SIDE_W (3 * NB),
        .STEPS  (ISQ_STEPS)
    ) u_isqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_v),
        .i_rad   (RAD_W'(r_h_ns)),
        .i_side  (r_h_c),
        .o_valid (w_sn_v),
        .o_root  (w_root),
        .o_side  (w_sn_c)
    );

    // stage j: divider setup and threshold compare
    logic [2:0][NUM_W-1:0] r_j_num;
    logic [DEN_W-1:0]      r_j_den;
    t_dside                r_j_side;
    logic [DEN_W-1:0]      w_len;
    assign w_len = w_root[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else if (w_en) begin
            r_j_v <= w_sa_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j_den        <= w_len;
            r_j_side.area  <= w_area;
            r_j_side.degen <= w_area <= AREA_WIDTH'(r_thr);
            r_j_side.meta  <= w_sa_meta;
            for (int k = 0; k < 3; k++) begin
                r_j_num[k] <= (NUM_W'(w_sn_c[k]) << NORMAL_FRAC) + NUM_W'(w_len >> 1);
            end
        end
    end

    // normal division
    logic                w_dv;
    logic [2:0][Q_W-1:0] w_quo;
    t_dside              w_dside;

    tnac_div #(
        .LANES  (3),
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .Q_W    (Q_W),
        .SIDE_W ($bits(t_dside)),
        .STEPS  (DIV_STEPS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_j_v),
        .i_num   (r_j_num),
        .i_den   (r_j_den),
        .i_side  (r_j_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    // output register
    logic [AREA_WIDTH-1:0]   r_out_area;
    logic signed [N_W-1:0]   r_out_nrm [3];
    logic [2:0][CW-1:0]      r_out_ct;
    logic                    r_out_dg;
    logic signed [N_W-1:0]   n_nrm [3];

    assign w_en = !r_out_v || o_res.ready;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_dside.degen) begin
                n_nrm[k] = (k == 1) ? N_W'(Q_ONE) : '0;
            end else if (w_dside.meta.neg[k]) begin
                n_nrm[k] = -N_W'((w_quo[k] > Q_ONE) ? Q_ONE : w_quo[k]);
            end else begin
                n_nrm[k] = N_W'((w_quo[k] > Q_ONE) ? Q_ONE : w_quo[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_area <= w_dside.area;
            r_out_dg   <= w_dside.degen;
            r_out_ct   <= w_dside.meta.center;
            for (int k = 0; k < 3; k++) begin
                r_out_nrm[k] <= n_nrm[k];
            end
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.area       = r_out_area;
    assign o_res.normal_x   = r_out_nrm[0];
    assign o_res.normal_y   = r_out_nrm[1];
    assign o_res.normal_z   = r_out_nrm[2];
    assign o_res.center_x   = $signed(r_out_ct[0]);
    assign o_res.center_y   = $signed(r_out_ct[1]);
    assign o_res.center_z   = $signed(r_out_ct[2]);
    assign o_res.degenerate = r_out_dg;

    // checks
    a_sqrt_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sa_v == w_sn_v)
        else $error("square root pipes out of step");

    a_area_over_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.degenerate |-> o_res.area > AREA_WIDTH'(r_thr))
        else $error("valid normal with area at or below threshold");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv && !w_dside.degen |-> (w_quo[0] <= Q_ONE + Q_W'(1))
            && (w_quo[1] <= Q_ONE + Q_W'(1)) && (w_quo[2] <= Q_ONE + Q_W'(1)))
        else $error("normal quotient out of range");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: triangle normal, area and centroid testbench
// drives triangle beats and threshold writes, predicts each result beat from
// the vertices and the current threshold, and checks every field; random
// idling on both channels plus a long output hold-off to fill the pipe
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tnac_pkg::*;

    localparam int  PIPE_LAT  = 37;
    localparam int  MAX_CYCLE = 2000000;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] v [9];
    } t_tri;

    typedef struct {
        logic [AREA_WIDTH-1:0]         area;
        logic signed [NORMAL_FRAC+1:0] nrm [3];
        logic signed [COORD_WIDTH-1:0] ctr [3];
        logic                          degen;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tnac_in_if  tri_ch ();
    tnac_cfg_if cfg_ch ();
    tnac_out_if res_ch ();

    triangle_normal_area_centroid dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_res   (res_ch.source)
    );

    t_res                 pending_res [$];
    logic [THR_WIDTH-1:0] thr_model = '0;
    int                   fails = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_cycles = 0;
    int                   cycle_cnt = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        tri_ch.valid = 1'b0;
        tri_ch.p0_x = '0; tri_ch.p0_y = '0; tri_ch.p0_z = '0;
        tri_ch.p1_x = '0; tri_ch.p1_y = '0; tri_ch.p1_z = '0;
        tri_ch.p2_x = '0; tri_ch.p2_y = '0; tri_ch.p2_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.area_threshold = '0;
        res_ch.ready = 1'b0;
    end

    function automatic logic [63:0] isqrt128(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tt;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            tt = 128'(t) * 128'(t);
            if (tt <= x) r = t;
        end
        return r;
    endfunction

    function automatic int bit_len(logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic t_res predict_result(t_tri t, logic [THR_WIDTH-1:0] thr);
        longint      p [9];
        longint      e1 [3];
        longint      e2 [3];
        longint      cr [3];
        logic [63:0] mag [3];
        logic [63:0] sc [3];
        logic [127:0] ssq;
        logic [63:0] ar;
        logic [63:0] len;
        logic [63:0] nsum;
        logic [63:0] n;
        longint      s;
        longint      q;
        int          b;
        logic        big;
        t_res        r;
        for (int i = 0; i < 9; i++) p[i] = longint'(t.v[i]);
        for (int i = 0; i < 3; i++) begin
            e1[i] = p[3+i] - p[i];
            e2[i] = p[6+i] - p[i];
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        big = 1'b0;
        ssq = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (cr[i] < 0) ? 64'(-cr[i]) : 64'(cr[i]);
            if (mag[i] >= (64'd1 << 50)) big = 1'b1;
            ssq += 128'(mag[i]) * 128'(mag[i]);
        end
        if (big) begin
            ar = (64'd1 << AREA_WIDTH) - 1;
        end else begin
            ar = isqrt128(ssq >> (2 * AREA_SHIFT));
            if (ar > (64'd1 << AREA_WIDTH) - 1) ar = (64'd1 << AREA_WIDTH) - 1;
        end
        r.area = ar[AREA_WIDTH-1:0];
        r.degen = (ar <= 64'(thr));
        if (!r.degen) begin
            b = 0;
            for (int i = 0; i < 3; i++) if (bit_len(mag[i]) > b) b = bit_len(mag[i]);
            nsum = '0;
            for (int i = 0; i < 3; i++) begin
                sc[i] = (b > NORM_BITS) ? (mag[i] >> (b - NORM_BITS))
                                        : (mag[i] << (NORM_BITS - b));
                nsum += sc[i] * sc[i];
            end
            len = isqrt128(128'(nsum));
            if (b == 0 || len == 0) begin
                r.degen = 1'b1;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    n = ((sc[i] << NORMAL_FRAC) + (len >> 1)) / len;
                    if (n > (64'd1 << NORMAL_FRAC)) n = 64'd1 << NORMAL_FRAC;
                    r.nrm[i] = (cr[i] < 0) ? -(NORMAL_FRAC+2)'(n) : (NORMAL_FRAC+2)'(n);
                end
            end
        end
        if (r.degen) begin
            r.nrm[0] = '0;
            r.nrm[1] = (NORMAL_FRAC+2)'(1 << NORMAL_FRAC);
            r.nrm[2] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            s = p[i] + p[3+i] + p[6+i] + 1;
            q = s / 3;
            if (s % 3 < 0) q--;
            r.ctr[i] = COORD_WIDTH'(q);
        end
        return r;
    endfunction

    task automatic send_tri(t_tri t);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            tri_ch.valid = 1'b0;
        end
        @(negedge i_clk);
        tri_ch.valid = 1'b1;
        tri_ch.p0_x = t.v[0]; tri_ch.p0_y = t.v[1]; tri_ch.p0_z = t.v[2];
        tri_ch.p1_x = t.v[3]; tri_ch.p1_y = t.v[4]; tri_ch.p1_z = t.v[5];
        tri_ch.p2_x = t.v[6]; tri_ch.p2_y = t.v[7]; tri_ch.p2_z = t.v[8];
        do @(posedge i_clk); while (!tri_ch.ready);
        pending_res.push_back(predict_result(t, thr_model));
    endtask

    task automatic end_stream();
        @(negedge i_clk);
        tri_ch.valid = 1'b0;
    endtask

    task automatic write_threshold(logic [THR_WIDTH-1:0] thr);
        end_stream();
        wait (pending_res.size() == 0);
        repeat (PIPE_LAT + 5) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.area_threshold = thr;
        do @(posedge i_clk); while (!cfg_ch.ready);
        thr_model = thr;
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_tri make_tri(int c [9]);
        t_tri t;
        for (int i = 0; i < 9; i++) t.v[i] = COORD_WIDTH'(c[i]);
        return t;
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   sel;
        int   base [3];
        int   span;
        sel = $urandom_range(9);
        if (sel < 4) begin
            for (int i = 0; i < 9; i++) t.v[i] = COORD_WIDTH'($urandom);
        end else if (sel < 8) begin
            span = (sel < 6) ? 8192 : 1 << $urandom_range(20);
            for (int i = 0; i < 3; i++) base[i] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
            for (int i = 0; i < 9; i++)
                t.v[i] = COORD_WIDTH'(base[i % 3] + $urandom_range(0, span) - span / 2);
        end else begin
            span = $urandom_range(1, 64);
            for (int i = 0; i < 3; i++) begin
                base[i] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                t.v[i] = COORD_WIDTH'(base[i]);
                t.v[3+i] = COORD_WIDTH'(base[i] + span * (i + 1));
                t.v[6+i] = COORD_WIDTH'(base[i] + 2 * span * (i + 1));
            end
        end
        return t;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_res.size() == 0) begin
                $error("result beat with nothing expected");
                fails++;
            end else begin
                e = pending_res.pop_front();
                check_field("area", 64'(e.area), 64'(res_ch.area));
                check_field("normal_x", 64'(e.nrm[0]), 64'(res_ch.normal_x));
                check_field("normal_y", 64'(e.nrm[1]), 64'(res_ch.normal_y));
                check_field("normal_z", 64'(e.nrm[2]), 64'(res_ch.normal_z));
                check_field("center_x", 64'(e.ctr[0]), 64'(res_ch.center_x));
                check_field("center_y", 64'(e.ctr[1]), 64'(res_ch.center_y));
                check_field("center_z", 64'(e.ctr[2]), 64'(res_ch.center_z));
                check_field("degenerate", 64'(e.degen), 64'(res_ch.degenerate));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed();
        localparam int MX = (1 << (COORD_WIDTH - 1)) - 1;
        localparam int MN = -(1 << (COORD_WIDTH - 1));
        send_tri(make_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_tri(make_tri('{5, 5, 5, 5, 5, 5, 5, 5, 5}));
        send_tri(make_tri('{0, 0, 0, 4096, 0, 0, 0, 4096, 0}));
        send_tri(make_tri('{0, 0, 0, 0, 4096, 0, 4096, 0, 0}));
        send_tri(make_tri('{0, 0, 0, 0, 0, 4096, 4096, 0, 0}));
        send_tri(make_tri('{0, 0, 0, 0, 4096, 0, 0, 0, 4096}));
        send_tri(make_tri('{MN, MN, MN, MX, MN, MN, MN, MX, MN}));
        send_tri(make_tri('{MN, MN, MN, MX, MX, MN, MN, MX, MX}));
        send_tri(make_tri('{MX, MX, MX, MN, MX, MX, MX, MN, MX}));
        send_tri(make_tri('{MN, MX, MN, MX, MN, MX, MN, MN, MX}));
        send_tri(make_tri('{MX, MX, MX, MX, MX, MX, MX, MX, MX}));
        send_tri(make_tri('{MN, MN, MN, MN, MN, MN, MN, MN, MN}));
        send_tri(make_tri('{1, 2, 3, 2, 4, 6, 3, 6, 9}));
        send_tri(make_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
        send_tri(make_tri('{0, 0, 0, 8192, 0, 0, 0, 8192, 0}));
        send_tri(make_tri('{-1, -1, -1, -2, 0, 1, 1, -1, 0}));
        send_tri(make_tri('{100, -200, 300, -4000, 5000, 60, 7, -8, 9000}));
        send_tri(make_tri('{0, 0, 0, MX, 1, 0, 1, MX, 0}));
        end_stream();
    endtask

    task automatic test_threshold_edges();
        write_threshold('1);
        send_tri(make_tri('{0, 0, 0, 8192, 0, 0, 0, 8191, 0}));
        send_tri(make_tri('{0, 0, 0, 8192, 0, 0, 0, 8192, 0}));
        send_tri(make_tri('{0, 0, 0, 8192, 0, 0, 0, 8193, 0}));
        send_tri(make_tri('{0, 0, 0, 5000, 0, 0, 0, 0, 5000}));
        write_threshold(12'd1);
        send_tri(make_tri('{0, 0, 0, 181, 0, 0, 0, 181, 0}));
        send_tri(make_tri('{0, 0, 0, 128, 0, 0, 0, 128, 0}));
        send_tri(make_tri('{0, 0, 0, 129, 0, 0, 0, 128, 0}));
        end_stream();
    endtask

    task automatic test_random(int n_items, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_threshold(THR_WIDTH'($urandom));
        for (int i = 0; i < n_items; i++) begin
            send_tri(rand_tri());
            if (i == n_items / 2) write_threshold(THR_WIDTH'($urandom_range(0, 3) == 0 ?
                                                  0 : $urandom));
        end
        end_stream();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        hold_cycles = 200;
        for (int i = 0; i < 120; i++) send_tri(rand_tri());
        end_stream();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_threshold_edges();
        write_threshold('0);
        test_directed();
        test_random(240, 28, 76);
        test_random(240, 76, 28);
        test_random(240, 0, 0);
        test_backpressure();
        write_threshold('1);
        test_random(40, 0, 0);
        wait (pending_res.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/tnac_pkg.sv
design/tnac_if.sv
design/tnac_isqrt.sv
design/tnac_div.sv
design/triangle_normal_area_centroid.sv
tb/tb.sv
